/* design/mfq_pkg.sv */
// ----------------------------------------------------------------------------
// mfq_pkg
// shared types and constants of the three-level feedback queue scheduler
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int AGE_BITS_DEF    = 10;

  localparam int CFG_DATA_BITS  = 10;
  localparam int CFG_INDEX_BITS = 4;
  localparam int QUANT_BITS     = 4;
  localparam int LEVEL_BITS     = 2;
  localparam int REQ_BITS       = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PROMOTE_AGE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTUM_TOP = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTUM_MID = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTUM_LOW = 4'd3;

  localparam logic [CFG_DATA_BITS-1:0] PROMOTE_AGE_RST = 10'd1000;
  localparam logic [QUANT_BITS-1:0]    QUANTUM_TOP_RST = 4'd4;
  localparam logic [QUANT_BITS-1:0]    QUANTUM_MID_RST = 4'd4;
  localparam logic [QUANT_BITS-1:0]    QUANTUM_LOW_RST = 4'd1;

  localparam logic [REQ_BITS-1:0] REQ_ADD      = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_TICK     = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_DISPATCH = 2'd2;

  localparam logic [LEVEL_BITS-1:0] LVL_TOP = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_MID = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_LOW = 2'd2;

  // operation on one queue row in one cycle
  typedef struct packed {
    logic shift;  // drop head, every cell but the last takes its right neighbour
    logic push;   // write an entry at the tail
  } queue_op_t;

endpackage

/* design/mfq_cell.sv */
// ----------------------------------------------------------------------------
// mfq_cell
// one queue slot: holds an entry, takes its neighbour on shift or new data
// ----------------------------------------------------------------------------
module mfq_cell #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] nbr,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (wr) begin
      q <= wdata;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

/* design/mfq_queue.sv */
// ----------------------------------------------------------------------------
// mfq_queue
// fifo built as a row of cells, head in cell 0, with a fill count
// ----------------------------------------------------------------------------
module mfq_queue #(
  parameter int DEPTH = 16,
  parameter int W     = 18,
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  mfq_pkg::queue_op_t op,
  input  logic [W-1:0]       wdata,
  output logic [W-1:0]       head,
  output logic [FW-1:0]      fill
);
  import mfq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  cells [DEPTH];
  logic [FW-1:0] wr_pos;
  logic [FW-1:0] fill_next;

  // on shift and push together the tail slot moves down by one
  assign wr_pos = op.shift ? fill - FW'(1) : fill;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      logic [W-1:0] nbr;
      if (k < DEPTH - 1) begin : g_mid
        assign nbr = cells[k+1];
      end else begin : g_end
        assign nbr = cells[k];
      end
      mfq_cell #(.W(W)) u_cell (
        .clk   (clk),
        .shift (op.shift),
        .nbr   (nbr),
        .wr    (op.push && (wr_pos[IW-1:0] == IW'(k))),
        .wdata (wdata),
        .q     (cells[k])
      );
    end
  endgenerate

  assign head = cells[0];

  always_comb begin
    fill_next = fill;
    if (op.push && !op.shift) begin
      fill_next = fill + FW'(1);
    end else if (op.shift && !op.push) begin
      fill_next = fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

/* design/multilevel_feedback_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// three-level feedback queue scheduler on rows of shifting cells
// ----------------------------------------------------------------------------
// An add or a dispatch is taken at once and its result beat shows on done
// in the next cycle; busy stays low, so a new command may follow at once. A
// tick walks level 2 and then level 1 one entry per cycle, rotating the head
// of the row to its tail or to the tail of the level above; the level 1 walk
// covers fill_mid as it stands after the level 2 walk, and busy is high
// meanwhile. done lasts one cycle and cannot be held off.
module multilevel_feedback_scheduler_unit #(
  parameter int QUEUE_DEPTH = mfq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = mfq_pkg::ID_BITS_DEF,
  parameter int AGE_BITS    = mfq_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mfq_pkg::REQ_BITS-1:0]        req_type,
  input  logic [ID_BITS-1:0]                  proc_id,
  input  logic [mfq_pkg::LEVEL_BITS-1:0]      level,
  input  logic [AGE_BITS-1:0]                 start_age,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mfq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                done,
  output logic                                accepted,
  output logic                                granted,
  output logic [ID_BITS-1:0]                  granted_id,
  output logic [mfq_pkg::LEVEL_BITS-1:0]      granted_level,
  output logic [mfq_pkg::QUANT_BITS-1:0]      quantum,
  output logic                                has_any
);
  import mfq_pkg::*;

  localparam int W  = ID_BITS + AGE_BITS;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (AGE_BITS > CFG_DATA_BITS) ? AGE_BITS : CFG_DATA_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_LOW,
    ST_WALK_MID
  } state_t;

  state_t state;
  logic [FW-1:0] cnt;

  logic [CFG_DATA_BITS-1:0] promote_age;
  logic [QUANT_BITS-1:0]    quantum_top;
  logic [QUANT_BITS-1:0]    quantum_mid;
  logic [QUANT_BITS-1:0]    quantum_low;

  queue_op_t     op_top, op_mid, op_low;
  logic [W-1:0]  wd_top, wd_mid, wd_low;
  logic [W-1:0]  head_top, head_mid, head_low;
  logic [FW-1:0] fill_top, fill_mid, fill_low;

  mfq_queue #(.DEPTH(QUEUE_DEPTH), .W(W), .FW(FW)) u_top (
    .clk(clk), .rst(rst), .op(op_top), .wdata(wd_top), .head(head_top), .fill(fill_top)
  );
  mfq_queue #(.DEPTH(QUEUE_DEPTH), .W(W), .FW(FW)) u_mid (
    .clk(clk), .rst(rst), .op(op_mid), .wdata(wd_mid), .head(head_mid), .fill(fill_mid)
  );
  mfq_queue #(.DEPTH(QUEUE_DEPTH), .W(W), .FW(FW)) u_low (
    .clk(clk), .rst(rst), .op(op_low), .wdata(wd_low), .head(head_low), .fill(fill_low)
  );

  logic take;
  assign take      = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign has_any   = (fill_top != '0) || (fill_mid != '0) || (fill_low != '0);

  // aging of the head entry of the row being walked
  logic [W-1:0]        walk_head;
  logic [AGE_BITS-1:0] walk_age, walk_age_inc;
  logic [FW-1:0]       up_fill;
  logic                promote;

  always_comb begin
    walk_head    = (state == ST_WALK_LOW) ? head_low : head_mid;
    up_fill      = (state == ST_WALK_LOW) ? fill_mid : fill_top;
    walk_age     = walk_head[AGE_BITS-1:0];
    walk_age_inc = (walk_age == AGE_MAX) ? walk_age : walk_age + AGE_BITS'(1);
    promote      = (CW'(walk_age_inc) >= CW'(promote_age)) && (up_fill != FULL);
  end

  logic add_ok;
  assign add_ok = (level == LVL_TOP && fill_top != FULL) ||
                  (level == LVL_MID && fill_mid != FULL) ||
                  (level == LVL_LOW && fill_low != FULL);

  always_comb begin
    op_top = '0;
    op_mid = '0;
    op_low = '0;
    wd_top = {proc_id, start_age};
    wd_mid = {proc_id, start_age};
    wd_low = {proc_id, start_age};
    unique case (state)
      ST_IDLE: begin
        if (take && req_type == REQ_ADD && add_ok) begin
          op_top.push = (level == LVL_TOP);
          op_mid.push = (level == LVL_MID);
          op_low.push = (level == LVL_LOW);
        end else if (take && req_type == REQ_DISPATCH) begin
          op_top.shift = (fill_top != '0);
          op_mid.shift = (fill_top == '0) && (fill_mid != '0);
          op_low.shift = (fill_top == '0) && (fill_mid == '0) && (fill_low != '0);
        end
      end
      ST_WALK_LOW: begin
        if (cnt != '0) begin
          op_low.shift = 1'b1;
          if (promote) begin
            op_mid.push = 1'b1;
            wd_mid      = {walk_head[W-1:AGE_BITS], AGE_BITS'(0)};
          end else begin
            op_low.push = 1'b1;
            wd_low      = {walk_head[W-1:AGE_BITS], walk_age_inc};
          end
        end
      end
      ST_WALK_MID: begin
        if (cnt != '0) begin
          op_mid.shift = 1'b1;
          if (promote) begin
            op_top.push = 1'b1;
            wd_top      = {walk_head[W-1:AGE_BITS], AGE_BITS'(0)};
          end else begin
            op_mid.push = 1'b1;
            wd_mid      = {walk_head[W-1:AGE_BITS], walk_age_inc};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      promote_age <= PROMOTE_AGE_RST;
      quantum_top <= QUANTUM_TOP_RST;
      quantum_mid <= QUANTUM_MID_RST;
      quantum_low <= QUANTUM_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROMOTE_AGE: promote_age <= cfg_data;
        REG_QUANTUM_TOP: quantum_top <= cfg_data[QUANT_BITS-1:0];
        REG_QUANTUM_MID: quantum_mid <= cfg_data[QUANT_BITS-1:0];
        REG_QUANTUM_LOW: quantum_low <= cfg_data[QUANT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      done          <= 1'b0;
      accepted      <= 1'b0;
      granted       <= 1'b0;
      granted_id    <= '0;
      granted_level <= '0;
      quantum       <= '0;
    end else begin
      done          <= 1'b0;
      accepted      <= 1'b0;
      granted       <= 1'b0;
      granted_id    <= '0;
      granted_level <= '0;
      quantum       <= '0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            priority if (req_type == REQ_TICK) begin
              state <= ST_WALK_LOW;
              cnt   <= fill_low;
            end else if (req_type == REQ_ADD) begin
              done     <= 1'b1;
              accepted <= add_ok;
            end else if (req_type == REQ_DISPATCH) begin
              done <= 1'b1;
              if (fill_top != '0) begin
                granted       <= 1'b1;
                granted_id    <= head_top[W-1:AGE_BITS];
                granted_level <= LVL_TOP;
                quantum       <= quantum_top;
              end else if (fill_mid != '0) begin
                granted       <= 1'b1;
                granted_id    <= head_mid[W-1:AGE_BITS];
                granted_level <= LVL_MID;
                quantum       <= quantum_mid;
              end else if (fill_low != '0) begin
                granted       <= 1'b1;
                granted_id    <= head_low[W-1:AGE_BITS];
                granted_level <= LVL_LOW;
                quantum       <= quantum_low;
              end
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_WALK_LOW: begin
          if (cnt == '0) begin
            // level 1 walk covers entries promoted from level 2 as well
            state <= ST_WALK_MID;
            cnt   <= fill_mid;
          end else begin
            cnt <= cnt - FW'(1);
          end
        end
        ST_WALK_MID: begin
          if (cnt == '0) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - FW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_top <= FULL && fill_mid <= FULL && fill_low <= FULL)
    else $error("queue fill beyond depth");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    !(accepted && granted))
    else $error("add and dispatch result in one beat");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while walking");

  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    granted |-> $past(fill_top != '0 || fill_mid != '0 || fill_low != '0))
    else $error("grant from empty scheduler");
`endif

endmodule
